// ===== rtl/spiral_scan_address_gen_unit_defines.svh =====
// Assertion macros for the spiral scan address generator.
// Used by the RTL files that carry assertions; depends on clk and rst_n in scope.
`ifndef SPIRAL_SCAN_ADDRESS_GEN_UNIT_DEFINES_SVH
`define SPIRAL_SCAN_ADDRESS_GEN_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every clock edge out of reset
`define SSAG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define SSAG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSAG_ASSERT(lbl, prop, msg)
`define SSAG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/ssag_pkg.sv =====
// Shared constants for the spiral scan address generator.
// No dependencies; imported by ssag_step and spiral_scan_address_gen_unit.
package ssag_pkg;

    localparam int MAX_SIDE_DEFAULT = 16;
    localparam int SIDE_RESET       = 16;

    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CORNER = 1'b1;

    // start corners
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;
    localparam logic [1:0] CORNER_RESET = CORNER_TL;

    // headings, in clockwise order
    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_DOWN  = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    typedef struct packed {
        logic walk_done;
        logic has_successor;
    } step_flags_t;

endpackage

// ===== rtl/ssag_step.sv =====
// One step of the spiral walk: arm on restart, emit the current cell, advance.
// Depends on ssag_pkg; pure combinational, the state lives in the top level.
module ssag_step
    import ssag_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT,
    localparam int POS_W  = $clog2(MAX_SIDE),
    localparam int SIDE_W = $clog2(MAX_SIDE + 1),
    localparam int IDX_W  = $clog2(MAX_SIDE * MAX_SIDE),
    localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1)
)
(
    input  logic              restart,
    input  logic [SIDE_W-1:0] side,
    input  logic [1:0]        corner,
    input  logic [CNT_W-1:0]  total,
    input  logic [POS_W-1:0]  row,
    input  logic [POS_W-1:0]  col,
    input  logic [1:0]        heading,
    input  logic [POS_W-1:0]  rmin,
    input  logic [POS_W-1:0]  rmax,
    input  logic [POS_W-1:0]  cmin,
    input  logic [POS_W-1:0]  cmax,
    input  logic [IDX_W-1:0]  idx,
    input  logic [CNT_W-1:0]  cnt,
    output logic [POS_W-1:0]  row_next,
    output logic [POS_W-1:0]  col_next,
    output logic [1:0]        heading_next,
    output logic [POS_W-1:0]  rmin_next,
    output logic [POS_W-1:0]  rmax_next,
    output logic [POS_W-1:0]  cmin_next,
    output logic [POS_W-1:0]  cmax_next,
    output logic [IDX_W-1:0]  idx_next,
    output logic [CNT_W-1:0]  cnt_next,
    output logic [IDX_W-1:0]  cell_idx,
    output logic [IDX_W-1:0]  succ_idx,
    output step_flags_t       flags
);

    logic [POS_W-1:0] last;
    logic [POS_W-1:0] row_a, col_a;
    logic [1:0]       head_a;
    logic [IDX_W-1:0] idx_a;
    logic [POS_W-1:0] row_c, col_c, rmin_c, rmax_c, cmin_c, cmax_c;
    logic [1:0]       head_c, head_m;
    logic [IDX_W-1:0] idx_c;
    logic [CNT_W-1:0] cnt_c, cnt_inc;
    logic             ahead_free;

    always_comb
    begin
        last = POS_W'(side - SIDE_W'(1));
        unique case (corner)
            CORNER_TL:
            begin
                row_a = '0;   col_a = '0;   head_a = HEAD_RIGHT;
                idx_a = '0;
            end
            CORNER_TR:
            begin
                row_a = '0;   col_a = last; head_a = HEAD_DOWN;
                idx_a = IDX_W'(side - SIDE_W'(1));
            end
            CORNER_BL:
            begin
                row_a = last; col_a = '0;   head_a = HEAD_UP;
                idx_a = IDX_W'(total - CNT_W'(side));
            end
            default:
            begin
                row_a = last; col_a = last; head_a = HEAD_LEFT;
                idx_a = IDX_W'(total - CNT_W'(1));
            end
        endcase

        row_c  = restart ? row_a  : row;
        col_c  = restart ? col_a  : col;
        head_c = restart ? head_a : heading;
        idx_c  = restart ? idx_a  : idx;
        cnt_c  = restart ? '0     : cnt;
        rmin_c = restart ? '0     : rmin;
        rmax_c = restart ? last   : rmax;
        cmin_c = restart ? '0     : cmin;
        cmax_c = restart ? last   : cmax;

        row_next     = row_c;
        col_next     = col_c;
        heading_next = head_c;
        rmin_next    = rmin_c;
        rmax_next    = rmax_c;
        cmin_next    = cmin_c;
        cmax_next    = cmax_c;
        idx_next     = idx_c;
        cnt_next     = cnt_c;
        cnt_inc      = cnt_c + CNT_W'(1);
        cell_idx     = '0;
        succ_idx     = '0;
        flags        = '0;
        ahead_free   = 1'b0;
        head_m       = head_c;

        if (cnt_c == total)
        begin
            flags.walk_done = 1'b1;
        end
        else
        begin
            cell_idx = idx_c;
            cnt_next = cnt_inc;
            if (cnt_inc != total)
            begin
                flags.has_successor = 1'b1;
                // the unvisited cells always form the rectangle of the bounds
                unique case (head_c)
                    HEAD_RIGHT: ahead_free = (col_c != cmax_c);
                    HEAD_DOWN:  ahead_free = (row_c != rmax_c);
                    HEAD_LEFT:  ahead_free = (col_c != cmin_c);
                    default:    ahead_free = (row_c != rmin_c);
                endcase
                if (!ahead_free)
                begin
                    // turn clockwise and drop the edge just finished
                    head_m = head_c + 2'd1;
                    unique case (head_c)
                        HEAD_RIGHT: rmin_next = rmin_c + POS_W'(1);
                        HEAD_DOWN:  cmax_next = cmax_c - POS_W'(1);
                        HEAD_LEFT:  rmax_next = rmax_c - POS_W'(1);
                        default:    cmin_next = cmin_c + POS_W'(1);
                    endcase
                end
                heading_next = head_m;
                unique case (head_m)
                    HEAD_RIGHT:
                    begin
                        col_next = col_c + POS_W'(1);
                        idx_next = idx_c + IDX_W'(1);
                    end
                    HEAD_DOWN:
                    begin
                        row_next = row_c + POS_W'(1);
                        idx_next = idx_c + IDX_W'(side);
                    end
                    HEAD_LEFT:
                    begin
                        col_next = col_c - POS_W'(1);
                        idx_next = idx_c - IDX_W'(1);
                    end
                    default:
                    begin
                        row_next = row_c - POS_W'(1);
                        idx_next = idx_c - IDX_W'(side);
                    end
                endcase
                succ_idx = idx_next;
            end
        end
    end

endmodule

// ===== rtl/spiral_scan_address_gen_unit.sv =====
// Spiral scan address generator top level: config registers, walk state, result register.
// Depends on ssag_pkg, ssag_step and spiral_scan_address_gen_unit_defines.svh.
// Latency: a result is valid in the cycle after its step beat is accepted.
// Throughput: one step per cycle unless a result waits; walk state updates in one ssag_step pass.
// The visited map is held as four shrinking bounds, so no memory and no clearing pass.
// Reset: side min(16, MAX_SIDE), top-left corner, walk armed so the first step emits cell 0.
`include "spiral_scan_address_gen_unit_defines.svh"
module spiral_scan_address_gen_unit
    import ssag_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 step_valid,
    output logic                 step_ready,
    input  logic                 restart,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [OUT_IDX_W-1:0] cell_index,
    output logic [OUT_IDX_W-1:0] successor_index,
    output logic                 has_successor,
    output logic                 walk_done
);

    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int IDX_W  = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int RST_SIDE  = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam int RST_TOTAL = RST_SIDE * RST_SIDE;

    logic [SIDE_W-1:0] side_reg;
    logic [1:0]        corner_reg;
    logic [CNT_W-1:0]  total_reg;
    logic              arm_pend_reg;
    logic [POS_W-1:0]  row_reg, col_reg, rmin_reg, rmax_reg, cmin_reg, cmax_reg;
    logic [1:0]        heading_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [POS_W-1:0]  row_next, col_next, rmin_next, rmax_next, cmin_next, cmax_next;
    logic [1:0]        heading_next;
    logic [IDX_W-1:0]  idx_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  cell_idx, succ_idx;
    step_flags_t       flags;

    logic                 result_valid_reg;
    logic [OUT_IDX_W-1:0] cell_index_reg, successor_index_reg;
    logic                 has_successor_reg, walk_done_reg;

    logic                      cfg_fire, step_fire;
    logic [SIDE_W-1:0]         side_new;
    logic [CNT_W-1:0]          total_new;
    logic [IDX_W+OUT_IDX_W-1:0] cell_ext, succ_ext;
    logic [IDX_W-1:0]          idx_calc;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign step_ready = !result_valid_reg || result_ready;
    assign step_fire  = step_valid && step_ready;

    // clamp the side to 1..MAX_SIDE
    always_comb
    begin
        if (cfg_data == '0)
            side_new = SIDE_W'(1);
        else if (32'(cfg_data) > 32'(MAX_SIDE))
            side_new = SIDE_W'(MAX_SIDE);
        else
            side_new = SIDE_W'(cfg_data);
        total_new = CNT_W'(CNT_W'(side_new) * CNT_W'(side_new));
    end

    ssag_step #(
        .MAX_SIDE (MAX_SIDE)
    ) u_step (
        .restart      (restart || arm_pend_reg),
        .side         (side_reg),
        .corner       (corner_reg),
        .total        (total_reg),
        .row          (row_reg),
        .col          (col_reg),
        .heading      (heading_reg),
        .rmin         (rmin_reg),
        .rmax         (rmax_reg),
        .cmin         (cmin_reg),
        .cmax         (cmax_reg),
        .idx          (idx_reg),
        .cnt          (cnt_reg),
        .row_next     (row_next),
        .col_next     (col_next),
        .heading_next (heading_next),
        .rmin_next    (rmin_next),
        .rmax_next    (rmax_next),
        .cmin_next    (cmin_next),
        .cmax_next    (cmax_next),
        .idx_next     (idx_next),
        .cnt_next     (cnt_next),
        .cell_idx     (cell_idx),
        .succ_idx     (succ_idx),
        .flags        (flags)
    );

    // indices wider than the port keep their low bits
    assign cell_ext = {{OUT_IDX_W{1'b0}}, cell_idx};
    assign succ_ext = {{OUT_IDX_W{1'b0}}, succ_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= SIDE_W'(RST_SIDE);
            corner_reg   <= CORNER_RESET;
            total_reg    <= CNT_W'(RST_TOTAL);
            arm_pend_reg <= 1'b1;
            row_reg      <= '0;
            col_reg      <= '0;
            heading_reg  <= HEAD_RIGHT;
            rmin_reg     <= '0;
            rmax_reg     <= '0;
            cmin_reg     <= '0;
            cmax_reg     <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (cfg_fire)
        begin
            // re-arm at the corner of the new settings on the next step
            arm_pend_reg <= 1'b1;
            unique case (cfg_index)
                REG_SIDE_LENGTH:
                begin
                    side_reg  <= side_new;
                    total_reg <= total_new;
                end
                REG_START_CORNER:
                begin
                    corner_reg <= cfg_data[1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (step_fire)
        begin
            arm_pend_reg <= 1'b0;
            row_reg      <= row_next;
            col_reg      <= col_next;
            heading_reg  <= heading_next;
            rmin_reg     <= rmin_next;
            rmax_reg     <= rmax_next;
            cmin_reg     <= cmin_next;
            cmax_reg     <= cmax_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (step_fire)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            cell_index_reg      <= cell_ext[OUT_IDX_W-1:0];
            successor_index_reg <= succ_ext[OUT_IDX_W-1:0];
            has_successor_reg   <= flags.has_successor;
            walk_done_reg       <= flags.walk_done;
        end
    end

    assign result_valid    = result_valid_reg;
    assign cell_index      = cell_index_reg;
    assign successor_index = successor_index_reg;
    assign has_successor   = has_successor_reg;
    assign walk_done       = walk_done_reg;

    assign idx_calc = IDX_W'(IDX_W'(row_reg) * IDX_W'(side_reg) + IDX_W'(col_reg));

    `SSAG_ASSERT(a_cnt_bound, !arm_pend_reg |-> cnt_reg <= total_reg, "cell count above grid size")
    `SSAG_ASSERT(a_pos_in_grid, !arm_pend_reg |-> row_reg < side_reg && col_reg < side_reg, "off grid")
    `SSAG_ASSERT(a_idx_match, !arm_pend_reg |-> idx_reg == idx_calc, "index out of step with position")
    `SSAG_ASSERT(a_done_at_end, result_valid_reg && walk_done_reg && !arm_pend_reg |-> cnt_reg == total_reg, "early done")

endmodule
